>>> hw/rtl/pfq_pkg.sv
package pfq_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned PROTO_W = 2;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 32;

    localparam logic [ADDR_W-1:0] BLACKLIST_RESET  = 32'hC0A8_0164;
    localparam logic [PORT_W-1:0] BAD_PORT_A_RESET = 16'd23;
    localparam logic [PORT_W-1:0] BAD_PORT_B_RESET = 16'd6666;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = 16'd1000;

    typedef enum logic [0:0] {
        ACT_ADD     = 1'b0,
        ACT_PROCESS = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_QUEUED       = 3'd0,
        ST_QUEUE_FULL   = 3'd1,
        ST_ALLOWED      = 3'd2,
        ST_BLOCKED      = 3'd3,
        ST_LOG_FULL     = 3'd4,
        ST_QUEUE_EMPTY  = 3'd5
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_BLACKLIST  = 2'd0,
        CFG_BAD_PORT_A = 2'd1,
        CFG_BAD_PORT_B = 2'd2,
        CFG_SIZE_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_addr;
        logic [PORT_W-1:0]  dest_port;
        logic [PROTO_W-1:0] proto;
        logic [SIZE_W-1:0]  pkt_size;
    } t_pkt;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  out_addr;
        logic [PORT_W-1:0]  out_port;
        logic [PROTO_W-1:0] out_proto;
        logic [SIZE_W-1:0]  out_size;
        logic [CNT_W-1:0]   queue_count;
        logic [CNT_W-1:0]   log_count;
    } t_result;

    typedef struct packed {
        logic latch;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/pfq_if.sv
interface pfq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [pfq_pkg::ADDR_W-1:0]    src_addr;
    logic [pfq_pkg::PORT_W-1:0]    dest_port;
    logic [pfq_pkg::PROTO_W-1:0]   proto;
    logic [pfq_pkg::SIZE_W-1:0]    pkt_size;

    modport source (output valid, action, src_addr, dest_port, proto, pkt_size, input ready);
    modport sink   (input valid, action, src_addr, dest_port, proto, pkt_size, output ready);
endinterface

interface pfq_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [pfq_pkg::ADDR_W-1:0]    out_addr;
    logic [pfq_pkg::PORT_W-1:0]    out_port;
    logic [pfq_pkg::PROTO_W-1:0]   out_proto;
    logic [pfq_pkg::SIZE_W-1:0]    out_size;
    logic [pfq_pkg::CNT_W-1:0]     queue_count;
    logic [pfq_pkg::CNT_W-1:0]     log_count;

    modport source (output valid, status, out_addr, out_port, out_proto, out_size,
                    queue_count, log_count, input ready);
    modport sink   (input valid, status, out_addr, out_port, out_proto, out_size,
                    queue_count, log_count, output ready);
endinterface

interface pfq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pfq_pkg::CIDX_W-1:0]    index;
    logic [pfq_pkg::CDATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pfq_ctrl.sv
module pfq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pfq_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pfq_pkg::t_cmd o_cmd
);

    pfq_pkg::t_state r_state;
    pfq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pfq_pkg::S_EXEC;
                end
            end
            pfq_pkg::S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = pfq_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.latch  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            pfq_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            pfq_pkg::S_EXEC: begin
                o_cmd.commit = i_sts.out_free;
            end
        endcase
    end

endmodule

>>> hw/rtl/pfq_dp.sv
module pfq_dp #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned LOG_DEPTH   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfq_pkg::t_cmd                 i_cmd,
    output pfq_pkg::t_sts                 o_sts,
    input  logic                          i_action,
    input  pfq_pkg::t_pkt                 i_pkt,
    input  logic                          i_cfg_we,
    input  logic [pfq_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [pfq_pkg::CDATA_W-1:0]   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output pfq_pkg::t_result              o_result
);

    localparam int unsigned QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QI_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned LI_W = $clog2(LOG_DEPTH + 1);
    localparam logic [QI_W-1:0] QUEUE_END = QI_W'(QUEUE_DEPTH);
    localparam logic [LI_W-1:0] LOG_END   = LI_W'(LOG_DEPTH);

    pfq_pkg::t_pkt r_queue_mem [QUEUE_DEPTH];
    pfq_pkg::t_pkt r_rd_data;

    logic [pfq_pkg::ADDR_W-1:0] r_blacklist;
    logic [pfq_pkg::PORT_W-1:0] r_bad_port_a;
    logic [pfq_pkg::PORT_W-1:0] r_bad_port_b;
    logic [pfq_pkg::SIZE_W-1:0] r_size_limit;

    logic                       r_action;
    pfq_pkg::t_pkt              r_pkt;
    logic [QI_W-1:0]            r_rd_idx;
    logic [QI_W-1:0]            r_wr_idx;
    logic [LI_W-1:0]            r_log_fill;
    logic                       r_out_valid;
    pfq_pkg::t_result           r_result;

    logic [QI_W-1:0]            n_rd_idx;
    logic [QI_W-1:0]            n_wr_idx;
    logic [LI_W-1:0]            n_log_fill;
    pfq_pkg::t_result           n_result;
    logic                       w_queue_we;
    logic                       w_bad;
    logic [QI_W-1:0]            w_rd_next;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blacklist  <= pfq_pkg::BLACKLIST_RESET;
            r_bad_port_a <= pfq_pkg::BAD_PORT_A_RESET;
            r_bad_port_b <= pfq_pkg::BAD_PORT_B_RESET;
            r_size_limit <= pfq_pkg::SIZE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (pfq_pkg::t_cfg_idx'(i_cfg_index))
                pfq_pkg::CFG_BLACKLIST:  r_blacklist  <= i_cfg_data;
                pfq_pkg::CFG_BAD_PORT_A: r_bad_port_a <= i_cfg_data[pfq_pkg::PORT_W-1:0];
                pfq_pkg::CFG_BAD_PORT_B: r_bad_port_b <= i_cfg_data[pfq_pkg::PORT_W-1:0];
                pfq_pkg::CFG_SIZE_LIMIT: r_size_limit <= i_cfg_data[pfq_pkg::SIZE_W-1:0];
            endcase
        end
    end

    // The read port runs every cycle, so the oldest entry is ready in the cycle after acceptance.
    always_ff @(posedge i_clk) begin
        if (w_queue_we) begin
            r_queue_mem[r_wr_idx[QA_W-1:0]] <= r_pkt;
        end
        r_rd_data <= r_queue_mem[r_rd_idx[QA_W-1:0]];
    end

    assign w_bad = (r_rd_data.src_addr == r_blacklist) ||
                   (r_rd_data.dest_port == r_bad_port_a) ||
                   (r_rd_data.dest_port == r_bad_port_b) ||
                   (r_rd_data.pkt_size > r_size_limit);
    assign w_rd_next = r_rd_idx + 1'b1;

    always_comb begin
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_log_fill = r_log_fill;
        w_queue_we = 1'b0;
        n_result   = '0;
        if (r_action == pfq_pkg::ACT_ADD) begin
            if (r_wr_idx >= QUEUE_END) begin
                n_result.status = pfq_pkg::ST_QUEUE_FULL;
            end else begin
                w_queue_we      = i_cmd.commit;
                n_wr_idx        = r_wr_idx + 1'b1;
                n_result.status = pfq_pkg::ST_QUEUED;
            end
        end else if (r_rd_idx >= r_wr_idx) begin
            n_result.status = pfq_pkg::ST_QUEUE_EMPTY;
        end else begin
            if (w_rd_next >= r_wr_idx) begin
                n_rd_idx = '0;
                n_wr_idx = '0;
            end else begin
                n_rd_idx = w_rd_next;
            end
            if (!w_bad) begin
                n_result.status = pfq_pkg::ST_ALLOWED;
            end else if (r_log_fill >= LOG_END) begin
                n_result.status = pfq_pkg::ST_LOG_FULL;
            end else begin
                n_log_fill      = r_log_fill + 1'b1;
                n_result.status = pfq_pkg::ST_BLOCKED;
            end
            n_result.out_addr  = r_rd_data.src_addr;
            n_result.out_port  = r_rd_data.dest_port;
            n_result.out_proto = r_rd_data.proto;
            n_result.out_size  = r_rd_data.pkt_size;
        end
        n_result.queue_count = pfq_pkg::CNT_W'(n_wr_idx - n_rd_idx);
        n_result.log_count   = pfq_pkg::CNT_W'(n_log_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_log_fill  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_rd_idx    <= n_rd_idx;
                r_wr_idx    <= n_wr_idx;
                r_log_fill  <= n_log_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_pkt    <= i_pkt;
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

endmodule

>>> hw/rtl/packet_filter_queue.sv
// Packet filter with a linear descriptor queue and a count of logged blocked packets.
// The input channel carries one transaction per action: an add stores a descriptor,
// a process takes the oldest one and checks it against the blacklisted address, the
// two suspicious ports and the size limit. Every transaction yields exactly one
// result transaction on the output channel, with status, both counts and the fields
// of a processed packet. The configuration channel writes the four filter registers
// and is always ready; it should only be used while no transaction is in flight.
// Each transaction is first accepted, while the queue memory read port fetches the
// oldest entry, and then evaluated, which updates the queue and log. The result is
// written to the output register when evaluation completes, and the next transaction
// is accepted only after the current one has been evaluated.
// A pending result that the receiver has not taken does not stop the next transaction
// from being accepted; if it is still waiting when the next one finishes, the block
// holds in its evaluation cycle and does not accept until the output is free.
// Reset empties the queue and the log and restores the default filter settings.
module packet_filter_queue #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned LOG_DEPTH   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfq_in_if.sink    i_in,
    pfq_out_if.source o_out,
    pfq_cfg_if.sink   i_cfg
);

    pfq_pkg::t_cmd    w_cmd;
    pfq_pkg::t_sts    w_sts;
    pfq_pkg::t_pkt    w_pkt;
    pfq_pkg::t_result w_result;

    assign w_pkt.src_addr  = i_in.src_addr;
    assign w_pkt.dest_port = i_in.dest_port;
    assign w_pkt.proto     = i_in.proto;
    assign w_pkt.pkt_size  = i_in.pkt_size;

    assign i_cfg.ready = 1'b1;

    pfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    pfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LOG_DEPTH   (LOG_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_action    (i_in.action),
        .i_pkt       (w_pkt),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_result    (w_result)
    );

    assign o_out.status      = w_result.status;
    assign o_out.out_addr    = w_result.out_addr;
    assign o_out.out_port    = w_result.out_port;
    assign o_out.out_proto   = w_result.out_proto;
    assign o_out.out_size    = w_result.out_size;
    assign o_out.queue_count = w_result.queue_count;
    assign o_out.log_count   = w_result.log_count;

endmodule
